FILE: rtl/core/lzss_token_bit_packer_unit_defines.svh
// Assertion macros shared by the LZSS token bit packer modules.
`ifndef LZSS_TOKEN_BIT_PACKER_UNIT_DEFINES_SVH
`define LZSS_TOKEN_BIT_PACKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LTBP_ASSERT_NOW(label, clk, rst, cond, expect_now) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
    else $error("ltbp: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define LTBP_ASSERT_NEXT(label, clk, rst, cond, expect_next) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error("ltbp: next-cycle check failed");

`endif

FILE: rtl/core/ltbp_pkg.sv
// Shared types and constants of the LZSS token bit packer.
package ltbp_pkg;

  localparam logic [1:0] REQ_LITERAL = 2'd0;
  localparam logic [1:0] REQ_MATCH   = 2'd1;
  localparam logic [1:0] REQ_FLUSH   = 2'd2;

  localparam int LEN_BIAS    = 3;
  localparam int OFFSET_BIAS = 1;
  localparam int LIT_BITS    = 9;
  localparam int MATCH_BITS  = 24;
  localparam int S_TDATA_W   = 40;
  localparam int QUEUE_DEPTH = 2;

  // One queue entry: up to three finished bytes, byte 0 goes out first.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
  } job_t;

endpackage

FILE: rtl/core/lzss_token_bit_packer_unit.sv
// A token taken by the front is written into the job queue; the back then loads it into
// its output register, and the first byte is driven from there onto the byte stream.
// One output byte per cycle while the receiver is ready and jobs are queued; a literal
// makes one or two bytes, a match three, a flush at most one. The byte stream sets the pace.
// Tokens are taken back to back while the job queue between front and back has room.
// Reset (rst, synchronous, active high) clears the pending bits, the queue and the
// output stage; the first token after reset starts on a byte boundary.
module lzss_token_bit_packer_unit
  import ltbp_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  // Token stream in.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // Fields from bit 0: literal_byte[7:0], match_length[16:8], match_offset[32:17],
  // zero padding[39:33].
  input  logic [S_TDATA_W-1:0] s_tdata,
  // Fields from bit 0: req_type[1:0] (literal, match or flush).
  input  logic [1:0]           s_tuser,
  // Byte stream out.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // Fields from bit 0: out_byte[7:0], first packed bit in bit 7.
  output logic [7:0]           m_tdata,
  // Marks the last byte caused by one token item.
  output logic                 m_tlast
);

  // The front merges each token with the held bits at once, so the held state
  // is always current and the next token can be taken in the next cycle if the
  // queue has room. It hands whole byte jobs (one to three bytes) to the queue.
  logic  q_full;
  logic  q_push;
  job_t  q_push_job;
  logic  q_valid;
  logic  q_pop;
  job_t  q_pop_job;

  ltbp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .req_type     (s_tuser),
    .literal_byte (s_tdata[7:0]),
    .match_length (s_tdata[16:8]),
    .match_offset (s_tdata[32:17]),
    .q_full       (q_full),
    .push         (q_push),
    .push_job     (q_push_job)
  );

  // The queue lets the front keep taking tokens while the back waits on a
  // stalled byte stream.
  ltbp_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (q_pop_job)
  );

  // The back drives the byte stream from registers and loads the next job in
  // the same cycle that the last byte of the current one is taken.
  ltbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_job    (q_pop_job),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: rtl/core/ltbp_front.sv
// Front part: accepts tokens, merges them with the pending bits and forms byte jobs.
`include "lzss_token_bit_packer_unit_defines.svh"
module ltbp_front
  import ltbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  literal_byte,
  input  logic [8:0]  match_length,
  input  logic [15:0] match_offset,
  input  logic        q_full,
  output logic        push,
  output job_t        push_job
);

  // Pending bits are kept left-aligned; bits below the count are zero.
  logic [6:0]  pend_bits;
  logic [2:0]  pend_count;
  logic [6:0]  pend_bits_next;
  logic [2:0]  pend_count_next;

  logic        accept;
  logic [7:0]  len_code;
  logic [14:0] off_code;
  logic [31:0] word_l;
  logic [4:0]  nbits;
  logic [4:0]  total;
  logic [31:0] aligned;
  logic        is_token;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  assign len_code = 8'(match_length - 9'(LEN_BIAS));
  assign off_code = 15'(match_offset - 16'(OFFSET_BIAS));

  always_comb begin
    word_l   = '0;
    nbits    = '0;
    is_token = 1'b0;
    case (req_type)
      REQ_LITERAL: begin
        word_l   = {1'b0, literal_byte, 23'd0};
        nbits    = 5'(LIT_BITS);
        is_token = 1'b1;
      end
      REQ_MATCH: begin
        word_l   = {1'b1, len_code, off_code, 8'd0};
        nbits    = 5'(MATCH_BITS);
        is_token = 1'b1;
      end
      default: begin
        word_l   = '0;
        nbits    = '0;
        is_token = 1'b0;
      end
    endcase
  end

  assign total   = {2'b00, pend_count} + nbits;
  assign aligned = {pend_bits, 25'd0} | (word_l >> pend_count);

  always_comb begin
    push            = 1'b0;
    push_job        = '0;
    pend_bits_next  = pend_bits;
    pend_count_next = pend_count;
    if (accept) begin
      if (is_token) begin
        push              = 1'b1;
        push_job.bytes[0] = aligned[31:24];
        push_job.bytes[1] = aligned[23:16];
        push_job.bytes[2] = aligned[15:8];
        push_job.nbytes   = total[4:3];
        pend_count_next   = total[2:0];
        case (total[4:3])
          2'd1:    pend_bits_next = aligned[23:17];
          2'd2:    pend_bits_next = aligned[15:9];
          default: pend_bits_next = aligned[7:1];
        endcase
      end else if (req_type == REQ_FLUSH && pend_count != 3'd0) begin
        push              = 1'b1;
        push_job.bytes[0] = {pend_bits, 1'b0};
        push_job.nbytes   = 2'd1;
        pend_bits_next    = '0;
        pend_count_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits  <= '0;
      pend_count <= '0;
    end else begin
      pend_bits  <= pend_bits_next;
      pend_count <= pend_count_next;
    end
  end

  `LTBP_ASSERT_NOW(a_pend_zero_fill, clk, rst, 1'b1, 7'(pend_bits << pend_count) == 7'd0)

endmodule

FILE: rtl/core/ltbp_queue.sv
// Short queue of byte jobs between the front and the back part.
`include "lzss_token_bit_packer_unit_defines.svh"
module ltbp_queue
  import ltbp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign pop_job = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `LTBP_ASSERT_NOW(a_no_overflow, clk, rst, 1'b1, count <= CNT_W'(DEPTH))

endmodule

FILE: rtl/core/ltbp_back.sv
// Back part: sends the bytes of each job one per cycle on the byte stream while it is ready.
`include "lzss_token_bit_packer_unit_defines.svh"
module ltbp_back
  import ltbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  job_t       cur;
  logic [1:0] idx;
  logic       busy;
  logic       done;

  assign m_tvalid = busy;
  assign m_tdata  = cur.bytes[idx];
  assign m_tlast  = busy && (idx == 2'(cur.nbytes - 2'd1));
  assign done     = busy && m_tready && m_tlast;
  assign pop      = q_valid && (!busy || done);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (done) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (busy && m_tready) begin
      idx <= idx + 1'b1;
    end
  end

  `LTBP_ASSERT_NEXT(a_more_bytes, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench that streams LZSS tokens into the bit packer and checks each byte.
`timescale 1ns / 1ps

module tb_top
  import ltbp_pkg::*;
();

  // Request code 3 is unused and must be ignored by the block.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_TOKENS = 230;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 8;

  // One expected byte on the output stream.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  // Keeps its own copy of the held bits and the bytes each token must produce.
  class byte_stream_scoreboard;
    logic [6:0]   held_bits;
    int           held_count;
    packed_byte_t expected_bytes[$];
    int           errors;

    function new();
      held_bits = '0;
      held_count = 0;
      errors = 0;
    endfunction

    // Appends right-aligned bits and queues every byte that becomes complete.
    function void append_bits(logic [23:0] bits, int nbits);
      logic [31:0]  acc;
      int           total;
      int           n;
      logic [7:0]   made[3];
      packed_byte_t entry;
      acc = (32'(held_bits) << nbits) | 32'(bits);
      total = held_count + nbits;
      n = 0;
      while (total >= 8) begin
        made[n] = 8'(acc >> (total - 8));
        n++;
        total -= 8;
      end
      held_bits = 7'(acc & ((32'd1 << total) - 32'd1));
      held_count = total;
      for (int i = 0; i < n; i++) begin
        entry.data = made[i];
        entry.last = (i == n - 1);
        expected_bytes.push_back(entry);
      end
    endfunction

    function void note_token(logic [1:0] req, logic [7:0] lit, logic [8:0] len,
                             logic [15:0] off);
      logic [8:0]   len_code;
      logic [15:0]  off_code;
      packed_byte_t entry;
      case (req)
        REQ_LITERAL: begin
          append_bits(24'(lit), LIT_BITS);
        end
        REQ_MATCH: begin
          // Length and offset are biased and then cut to 8 and 15 bits.
          len_code = len - 9'(LEN_BIAS);
          off_code = off - 16'(OFFSET_BIAS);
          append_bits({1'b1, len_code[7:0], off_code[14:0]}, MATCH_BITS);
        end
        REQ_FLUSH: begin
          // A flush with nothing held produces no byte.
          if (held_count != 0) begin
            entry.data = {1'b0, held_bits} << (8 - held_count);
            entry.last = 1'b1;
            expected_bytes.push_back(entry);
            held_bits = '0;
            held_count = 0;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      packed_byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("out_byte: no byte expected, actual %h (last %b)", data, last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %h, actual %h", want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %b, actual %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [1:0]           s_tuser = REQ_LITERAL;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 m_tlast;

  byte_stream_scoreboard sb = new();
  int cycle_count = 0;
  int tx_calm = 0;
  int rx_calm = 0;

  always #10 clk = ~clk;

  lzss_token_bit_packer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Draws the wait before the next item. Now and then a stretch of items is sent
  // or taken with no wait at all, so that back-to-back traffic is covered too.
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // Offers one token and returns at the edge where it is taken.
  task automatic send_token(logic [1:0] req, logic [7:0] lit, logic [8:0] len,
                            logic [15:0] off);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {7'b0, off, len, lit};
    do @(posedge clk); while (!s_tready);
  endtask

  // Draws a random token; out-of-range lengths and offsets appear now and then.
  task automatic send_random_token(output logic [1:0] req);
    int pick;
    logic [8:0]  len;
    logic [15:0] off;
    pick = $urandom_range(0, 99);
    if (pick < 42) req = REQ_LITERAL;
    else if (pick < 77) req = REQ_MATCH;
    else if (pick < 92) req = REQ_FLUSH;
    else req = REQ_UNUSED;
    len = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(3, 258));
    off = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                      : 16'($urandom_range(1, 32768));
    send_token(req, 8'($urandom_range(0, 255)), len, off);
  endtask

  // Accepted tokens are noted before bytes are checked; a byte leaving at some edge
  // always belongs to a token taken at an earlier edge, so the order is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_token(s_tuser, s_tdata[7:0], s_tdata[16:8], s_tdata[32:17]);
      end
      if (m_tvalid && m_tready) begin
        sb.check_byte(m_tdata, m_tlast);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The byte receiver stalls a random number of cycles before taking each byte.
  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = draw_gap(rx_calm);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    int         sent;
    logic [1:0] req;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A flush right after reset finds nothing held.
    send_token(REQ_FLUSH, 8'h00, 9'd3, 16'd1);
    send_token(REQ_LITERAL, 8'h00, 9'd0, 16'd0);
    send_token(REQ_LITERAL, 8'hFF, 9'd511, 16'hFFFF);
    send_token(REQ_FLUSH, 8'hFF, 9'd511, 16'hFFFF);
    // Smallest and largest legal match fields.
    send_token(REQ_MATCH, 8'h00, 9'd3, 16'd1);
    send_token(REQ_MATCH, 8'hFF, 9'd258, 16'd32768);
    send_token(REQ_LITERAL, 8'hA5, 9'd0, 16'd0);
    // Lengths and offsets outside their range wrap when they are biased.
    send_token(REQ_MATCH, 8'h00, 9'd259, 16'd0);
    send_token(REQ_MATCH, 8'hFF, 9'd0, 16'hFFFF);
    send_token(REQ_MATCH, 8'h3C, 9'd511, 16'd12345);
    send_token(REQ_MATCH, 8'hC3, 9'd2, 16'd2);
    // The unused request code must leave both the stream and the held bits alone.
    send_token(REQ_UNUSED, 8'hFF, 9'd511, 16'hFFFF);
    send_token(REQ_LITERAL, 8'h5A, 9'd511, 16'hFFFF);
    send_token(REQ_FLUSH, 8'h00, 9'd0, 16'd0);
    send_token(REQ_FLUSH, 8'h00, 9'd0, 16'd0);
    // Seven literals walk the held count from one up to seven, then a flush drains it.
    for (int i = 0; i < 7; i++) begin
      send_token(REQ_LITERAL, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                 16'($urandom_range(0, 65535)));
    end
    send_token(REQ_FLUSH, 8'h00, 9'd0, 16'd0);
    send_token(REQ_MATCH, 8'h00, 9'd130, 16'd16384);

    // Random part; ignored tokens do not count toward the total.
    sent = 0;
    while (sent < RANDOM_TOKENS) begin
      send_random_token(req);
      if (req != REQ_UNUSED) sent++;
    end
    send_token(REQ_FLUSH, 8'h00, 9'd0, 16'd0);
    s_tvalid <= 1'b0;
    // Let the monitor note the last token before the expected bytes are counted.
    @(posedge clk);

    // Wait for every expected byte, then watch a little longer for stray ones.
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ltbp_pkg.sv
rtl/core/ltbp_front.sv
rtl/core/ltbp_queue.sv
rtl/core/ltbp_back.sv
rtl/core/lzss_token_bit_packer_unit.sv
tb/sv/tb_top.sv
